@@ sv/dbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared types and constants for the ping-pong playback read cursor.
// ----------------------------------------------------------------------------
package dbpc_pkg;

    localparam int unsigned MAX_FRAMES  = 65536;
    localparam int unsigned MAX_REQUEST = 4096;
    localparam int unsigned MAX_SEGS    = 35;

    localparam int unsigned BF_W   = 17;  // buffer size register width
    localparam int unsigned CUR_W  = 16;  // cursor / frame index width
    localparam int unsigned CNT_W  = 13;  // request frame count width
    localparam int unsigned SEG_W  = 6;   // segment counter width

    // Request codes.
    localparam logic [2:0] REQ_READ   = 3'd0;
    localparam logic [2:0] REQ_PLAY   = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RESUME = 3'd4;
    localparam logic [2:0] REQ_FILL   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BUFFER_FRAMES = 2'd0;
    localparam logic [1:0] CFG_STREAM_MODE   = 2'd1;
    localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd2;

    localparam logic [BF_W-1:0] BUFFER_FRAMES_RST = 17'd4096;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [CNT_W-1:0] req_frames;
        logic             half_index;
    } t_in_item;

    typedef struct packed {
        logic [CUR_W-1:0] seg_start;
        logic [CNT_W-1:0] seg_frames;
        logic             zero_fill;
        logic [CNT_W-1:0] frames_reported;
        logic             playing_now;
        logic             last;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // latch the accepted request
        logic apply_req;  // apply a non-read request and emit its status item
        logic start;      // initialize a read
        logic calc;       // register take and full-region flag
        logic emit_seg;   // emit a copy segment and advance the cursor
        logic emit_zf;    // emit the zero-fill segment
        logic emit_stat;  // emit an empty status item
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;   // output register can take an item this cycle
        logic oob;        // cursor lies outside both halves
        logic brk;        // read loop ends here
        logic short_read; // frames remain for a zero fill
        logic no_segs;    // no copy segment emitted so far
    } t_status;

endpackage

@@ sv/dbpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dbpc_ctrl
// Sequencer that walks one request through status, copy and zero-fill items.
// ----------------------------------------------------------------------------
module dbpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_req_type,
    output logic              o_in_ready,
    input  dbpc_pkg::t_status i_status,
    output dbpc_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_REQ  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOOP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_ZF   = 3'd5;
    localparam logic [2:0] ST_STAT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_req_type == dbpc_pkg::REQ_READ) ? ST_READ : ST_REQ;
                end
            end
            ST_REQ: begin
                if (i_status.out_free) begin
                    o_cmd.apply_req = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (i_status.oob) begin
                    n_state = ST_STAT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state = ST_LOOP;
                end
            end
            ST_LOOP: begin
                o_cmd.calc = 1'b1;
                if (!i_status.brk) begin
                    n_state = ST_EMIT;
                end else if (i_status.short_read) begin
                    n_state = ST_ZF;
                end else if (i_status.no_segs) begin
                    n_state = ST_STAT;
                end else begin
                    // The last copy segment already carried the last flag.
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_seg = 1'b1;
                    n_state = ST_LOOP;
                end
            end
            ST_ZF: begin
                if (i_status.out_free) begin
                    o_cmd.emit_zf = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_STAT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/dbpc_datapath.sv @@
// ----------------------------------------------------------------------------
// dbpc_datapath
// Cursor, half flags, play state, configuration and the output register.
// ----------------------------------------------------------------------------
module dbpc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [dbpc_pkg::BF_W-1:0]      i_cfg_data,
    input  dbpc_pkg::t_in_item             i_in_item,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output dbpc_pkg::t_out_item            o_out_item,
    input  dbpc_pkg::t_cmd                 i_cmd,
    output dbpc_pkg::t_status              o_status
);

    localparam int unsigned BF_W  = dbpc_pkg::BF_W;
    localparam int unsigned CUR_W = dbpc_pkg::CUR_W;
    localparam int unsigned CNT_W = dbpc_pkg::CNT_W;
    localparam int unsigned SEG_W = dbpc_pkg::SEG_W;

    // Configuration.
    logic [BF_W-1:0] r_buffer_frames;
    logic            r_stream;
    logic            r_loop;

    // Persistent state.
    logic [CUR_W-1:0] r_cursor;
    logic [1:0]       r_half_done;
    logic             r_playing;
    logic             r_paused;

    // Per-request working registers.
    logic [2:0]       r_req;
    logic [CNT_W-1:0] r_n;
    logic             r_half;
    logic             r_idx;
    logic [CNT_W-1:0] r_done;
    logic [SEG_W-1:0] r_k;
    logic             r_halt;
    logic [CNT_W-1:0] r_take;
    logic             r_full;

    logic                r_out_valid;
    dbpc_pkg::t_out_item r_out;

    logic [CUR_W-1:0] n_cursor;
    logic [1:0]       n_half_done;
    logic             n_playing;
    logic             n_paused;

    logic [BF_W-1:0]  w_bf_clamp;
    logic [BF_W-1:0]  w_bf;
    logic [CUR_W-1:0] w_sub;
    logic [BF_W-1:0]  w_end;
    logic [BF_W-1:0]  w_avail;
    logic [CNT_W-1:0] w_rem;
    logic             w_rem_ge;
    logic [CNT_W-1:0] w_done_next;
    logic [BF_W-1:0]  w_sum;
    logic             w_stop_seg;
    logic             w_active;
    logic             w_out_free;
    logic [CNT_W-1:0] w_fc;
    dbpc_pkg::t_out_item w_item;

    // Effective buffer size: clamped, then rounded down to even.
    always_comb begin
        if (r_buffer_frames < BF_W'(2)) begin
            w_bf_clamp = BF_W'(2);
        end else if (r_buffer_frames > BF_W'(dbpc_pkg::MAX_FRAMES)) begin
            w_bf_clamp = BF_W'(dbpc_pkg::MAX_FRAMES);
        end else begin
            w_bf_clamp = r_buffer_frames;
        end
        w_bf  = {w_bf_clamp[BF_W-1:1], 1'b0};
        w_sub = w_bf[BF_W-1:1];
    end

    // In stream mode a segment ends at the end of the current half.
    assign w_end       = (r_stream && !r_idx) ? {1'b0, w_sub} : w_bf;
    assign w_avail     = w_end - {1'b0, r_cursor};
    assign w_rem       = r_n - r_done;
    assign w_rem_ge    = {{(BF_W-CNT_W){1'b0}}, w_rem} >= w_avail;
    assign w_done_next = r_done + r_take;
    assign w_sum       = {1'b0, r_cursor} + {{(BF_W-CNT_W){1'b0}}, r_take};
    assign w_stop_seg  = r_full && !r_loop;
    assign w_active    = r_playing && !r_paused;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_fc        = (i_in_item.req_frames > CNT_W'(dbpc_pkg::MAX_REQUEST))
                         ? CNT_W'(dbpc_pkg::MAX_REQUEST) : i_in_item.req_frames;

    always_comb begin
        o_status.out_free   = w_out_free;
        o_status.oob        = {1'b0, r_cursor} >= w_bf;
        o_status.brk        = r_halt || (r_done == r_n)
                              || (r_k >= SEG_W'(dbpc_pkg::MAX_SEGS))
                              || (r_stream && r_half_done[r_idx]);
        o_status.short_read = r_n > r_done;
        o_status.no_segs    = (r_k == '0);
    end

    // Next values of the persistent state.
    always_comb begin
        n_cursor    = r_cursor;
        n_half_done = r_half_done;
        n_playing   = r_playing;
        n_paused    = r_paused;
        if (i_cmd.apply_req) begin
            case (r_req)
                dbpc_pkg::REQ_PLAY: begin
                    n_playing = 1'b1;
                    n_paused  = 1'b0;
                    n_cursor  = '0;
                end
                dbpc_pkg::REQ_STOP: begin
                    if (w_active) begin
                        n_playing   = 1'b0;
                        n_paused    = 1'b0;
                        n_cursor    = '0;
                        n_half_done = 2'b11;
                    end
                end
                dbpc_pkg::REQ_PAUSE: begin
                    n_paused = 1'b1;
                end
                dbpc_pkg::REQ_RESUME: begin
                    n_paused = 1'b0;
                end
                dbpc_pkg::REQ_FILL: begin
                    n_half_done[r_half] = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.emit_seg) begin
            n_cursor = (w_sum == w_bf) ? '0 : w_sum[CUR_W-1:0];
            if (r_full) begin
                n_half_done[r_idx] = 1'b1;
            end
            // A completed region with looping off stops active playback.
            if (w_stop_seg && w_active) begin
                n_playing   = 1'b0;
                n_paused    = 1'b0;
                n_cursor    = '0;
                n_half_done = 2'b11;
            end
        end
    end

    // Item that goes into the output register.
    always_comb begin
        w_item = '0;
        w_item.last        = 1'b1;
        w_item.playing_now = w_active;
        if (i_cmd.apply_req) begin
            w_item.playing_now = n_playing && !n_paused;
        end else if (i_cmd.emit_seg) begin
            w_item.seg_start       = r_cursor;
            w_item.seg_frames      = r_take;
            w_item.frames_reported = w_done_next;
            w_item.playing_now     = w_stop_seg ? 1'b0 : w_active;
            w_item.last            = (w_done_next == r_n);
        end else if (i_cmd.emit_zf) begin
            w_item.seg_frames      = w_rem;
            w_item.zero_fill       = 1'b1;
            w_item.frames_reported = r_stream ? r_n : r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_frames <= dbpc_pkg::BUFFER_FRAMES_RST;
            r_stream        <= 1'b0;
            r_loop          <= 1'b0;
            r_cursor        <= '0;
            r_half_done     <= 2'b11;
            r_playing       <= 1'b0;
            r_paused        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dbpc_pkg::CFG_BUFFER_FRAMES: r_buffer_frames <= i_cfg_data;
                    dbpc_pkg::CFG_STREAM_MODE:   r_stream        <= i_cfg_data[0];
                    dbpc_pkg::CFG_LOOP_ENABLE:   r_loop          <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_cursor    <= n_cursor;
            r_half_done <= n_half_done;
            r_playing   <= n_playing;
            r_paused    <= n_paused;
            if (i_cmd.apply_req || i_cmd.emit_seg || i_cmd.emit_zf || i_cmd.emit_stat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in_item.req_type;
            r_n    <= w_fc;
            r_half <= i_in_item.half_index;
        end
        if (i_cmd.start) begin
            r_idx  <= r_cursor >= w_sub;
            r_done <= '0;
            r_k    <= '0;
            r_halt <= 1'b0;
        end
        if (i_cmd.calc) begin
            r_take <= w_rem_ge ? w_avail[CNT_W-1:0] : w_rem;
            r_full <= w_rem_ge;
        end
        if (i_cmd.emit_seg) begin
            r_done <= w_done_next;
            r_k    <= r_k + SEG_W'(1);
            if (r_full) begin
                r_idx <= !r_idx;
            end
            if (w_stop_seg) begin
                r_halt <= 1'b1;
            end
        end
        if (i_cmd.apply_req || i_cmd.emit_seg || i_cmd.emit_zf || i_cmd.emit_stat) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ sv/double_buffered_playback_cursor_top.sv @@
// ----------------------------------------------------------------------------
// double_buffered_playback_cursor_top
// Read-cursor controller of a ping-pong audio playback buffer.
// ----------------------------------------------------------------------------
// A request enters on the input channel (i_in_valid / o_in_ready). A read
// request is answered on the output channel (o_out_valid / i_out_ready) with
// up to 35 copy segments and then at most one zero-fill segment, or with a
// single status item if it yields neither; every other request gets a single
// status item. The final item of each request has its last flag set.
// A non-read request moves from acceptance to a request state, which puts its
// status item into the output register once that register is free. A read
// passes a setup state, then for each copy segment sizes it in one state and
// emits it and moves the cursor in another, then closes the loop and ends
// with a zero fill or a status item where one is due. A read whose cursor
// lies beyond both halves goes from setup straight to its status item. The
// sequencer handles one request at a time; a new request is accepted once
// the last item of the previous one sits in the output register. If the
// receiver stalls, the output register holds its item and the next item
// waits for it to drain; no item is dropped.
// Reset restores buffer_frames to 4096, stream and loop modes off, the cursor
// to 0, both halves marked processed and playback stopped. Configuration
// writes are taken on any cycle and belong between requests.
// ----------------------------------------------------------------------------
module double_buffered_playback_cursor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [dbpc_pkg::BF_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dbpc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dbpc_pkg::t_out_item           o_out_item
);

    dbpc_pkg::t_cmd    w_cmd;
    dbpc_pkg::t_status w_status;

    dbpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dbpc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
